>>> hdl/dipole_albedo_inversion_unit_macros.svh
// Assertion macros shared by the checker of the dipole albedo inversion unit.
`ifndef DIPOLE_ALBEDO_INVERSION_UNIT_MACROS_SVH
`define DIPOLE_ALBEDO_INVERSION_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DAI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DAI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dai_pkg.sv
// Types and constants shared by the dipole albedo inversion unit.
`timescale 1ns / 1ps

package dai_pkg;

    localparam int TGT_W   = 17;
    localparam int ALB_W   = 17;
    localparam int BT_W    = 20;
    localparam int TDATA_W = 24;
    localparam int LH_W    = 26;
    localparam int MID_W   = 25;
    localparam int GOAL_W  = 21;

    // Interval end that stands for 1.0 in Q1.25.
    localparam logic [LH_W-1:0] ONE25 = 26'h2000000;
    // Largest reflectance target, 1.0 in Q1.16.
    localparam logic [TGT_W-1:0] TGT_MAX = 17'h10000;
    // Reset value of the boundary term, 1.0 in Q4.16.
    localparam logic [BT_W-1:0] BT_RESET = 20'h10000;

    // Reciprocal of three for dividends below 2^27: floor(w / 3) = (w * M) >> 29.
    localparam logic [27:0] DIV3_M = 28'd178956971;
    // Below this dividend the quotient by three still fits 24 bits.
    localparam logic [26:0] X1_SAT_LIM = 27'd50331648;
    localparam logic [23:0] X_MAX = 24'hFFFFFF;

    localparam logic [30:0] ONE30 = 31'h40000000;
    localparam logic [20:0] ONE20 = 21'h100000;

    // Reciprocals for the Horner divisions by k: floor(y / k) = (y * M[k]) >> S[k].
    localparam logic [30:0] HORNER_M [1:12] = '{
        31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
        31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824,
        31'd1908874354, 31'd1717986919, 31'd1561806290, 31'd1431655766
    };
    localparam logic [5:0] HORNER_S [1:12] = '{
        6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd34
    };

    // Bisection interval and goal carried from step to step.
    typedef struct packed {
        logic [LH_W-1:0]   low;
        logic [LH_W-1:0]   high;
        logic [GOAL_W-1:0] goal;
    } bis_t;

endpackage

>>> hdl/dai_step.sv
// One pipelined bisection step: evaluates the dipole reflectance at the midpoint.
`timescale 1ns / 1ps

module dai_step (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [dai_pkg::BT_W-1:0]  boundary_term,
    input  logic                      in_valid,
    input  dai_pkg::bis_t             in_item,
    output logic                      out_valid,
    output dai_pkg::bis_t             out_item
);

    localparam int SQ_STAGES = 7;
    localparam int SQ_PER    = 3;
    localparam int HORNER    = 12;
    localparam int SQUARES   = 4;

    typedef struct packed {
        dai_pkg::bis_t                  item;
        logic [dai_pkg::MID_W-1:0]      mid;
    } carry_t;

    // One digit of the integer square root: returns {remainder, root}.
    function automatic logic [44:0] sqrt_digit(logic [23:0] rem, logic [20:0] q,
                                               logic [1:0] pair);
        logic [23:0] r2;
        logic [23:0] trial;
        r2    = {rem[21:0], pair};
        trial = {1'b0, q, 2'b01};
        if (r2 >= trial)
        begin
            return {r2 - trial, q[19:0], 1'b1};
        end
        return {r2, q[19:0], 1'b0};
    endfunction

    // Midpoint and square root operand.
    logic [dai_pkg::LH_W:0]    mid_sum;
    logic [dai_pkg::MID_W-1:0] mid_c;
    logic [20:0]               one_m_a;
    logic [21:0]               t_c;
    carry_t                    c0;

    always_comb
    begin
        mid_sum = {1'b0, in_item.low} + {1'b0, in_item.high};
        mid_c   = mid_sum[dai_pkg::MID_W:1];
        one_m_a = dai_pkg::ONE20 - {1'b0, mid_c[24:5]};
        t_c     = {one_m_a, 1'b0} + {1'b0, one_m_a};
        c0.item = in_item;
        c0.mid  = mid_c;
    end

    // Square root stages.
    logic        sq_valid_reg [0:SQ_STAGES];
    carry_t      sq_c_reg     [0:SQ_STAGES];
    logic [41:0] sq_v_reg     [0:SQ_STAGES];
    logic [23:0] sq_rem_reg   [0:SQ_STAGES];
    logic [20:0] sq_q_reg     [0:SQ_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_c_reg[0]   <= c0;
            sq_v_reg[0]   <= {t_c, 20'b0};
            sq_rem_reg[0] <= '0;
            sq_q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_sqrt
        logic [23:0] rem_c [0:SQ_PER];
        logic [20:0] q_c   [0:SQ_PER];

        // Three root digits per stage.
        always_comb
        begin
            rem_c[0] = sq_rem_reg[j];
            q_c[0]   = sq_q_reg[j];
            for (int m = 0; m < SQ_PER; m++)
            begin
                {rem_c[m+1], q_c[m+1]} = sqrt_digit(rem_c[m], q_c[m],
                    sq_v_reg[j][41 - 2*(SQ_PER*j + m) -: 2]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_c_reg[j+1]   <= sq_c_reg[j];
                sq_v_reg[j+1]   <= sq_v_reg[j];
                sq_rem_reg[j+1] <= rem_c[SQ_PER];
                sq_q_reg[j+1]   <= q_c[SQ_PER];
            end
        end
    end

    // Boundary term times root.
    logic        ae_valid_reg;
    carry_t      ae_c_reg;
    logic [20:0] ae_e_reg;
    logic [40:0] ae_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ae_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ae_valid_reg <= sq_valid_reg[SQ_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ae_c_reg    <= sq_c_reg[SQ_STAGES];
            ae_e_reg    <= sq_q_reg[SQ_STAGES];
            ae_prod_reg <= 41'(boundary_term) * 41'(sq_q_reg[SQ_STAGES]);
        end
    end

    // Division by three with saturation gives the first exponent.
    logic [26:0] w_c;
    logic [54:0] quo_full;
    logic [23:0] x1_c;

    always_comb
    begin
        w_c      = ae_prod_reg[40:14];
        quo_full = 55'(w_c) * 55'(dai_pkg::DIV3_M);
        x1_c     = (w_c >= dai_pkg::X1_SAT_LIM) ? dai_pkg::X_MAX : quo_full[52:29];
    end

    // Horner stages for both exponentials side by side.
    logic        hb_valid_reg [0:HORNER];
    carry_t      hb_c_reg     [0:HORNER];
    logic [29:0] hb_g1_reg    [0:HORNER];
    logic [29:0] hb_g2_reg    [0:HORNER];
    logic [30:0] hb_r1_reg    [0:HORNER];
    logic [30:0] hb_r2_reg    [0:HORNER];

    logic        ha_valid_reg [0:HORNER-1];
    carry_t      ha_c_reg     [0:HORNER-1];
    logic [29:0] ha_g1_reg    [0:HORNER-1];
    logic [29:0] ha_g2_reg    [0:HORNER-1];
    logic [29:0] ha_y1_reg    [0:HORNER-1];
    logic [29:0] ha_y2_reg    [0:HORNER-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            hb_valid_reg[0] <= ae_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hb_c_reg[0]  <= ae_c_reg;
            hb_g1_reg[0] <= {x1_c, 6'b0};
            hb_g2_reg[0] <= {3'b0, ae_e_reg, 6'b0};
            hb_r1_reg[0] <= dai_pkg::ONE30;
            hb_r2_reg[0] <= dai_pkg::ONE30;
        end
    end

    for (genvar h = 0; h < HORNER; h++)
    begin : g_horner
        localparam int K = HORNER - h;
        logic [60:0] pa1;
        logic [60:0] pa2;
        logic [60:0] pb1;
        logic [60:0] pb2;
        logic [60:0] sh1;
        logic [60:0] sh2;

        // Product with the running value, then division by k through a reciprocal.
        always_comb
        begin
            pa1 = 61'(hb_g1_reg[h]) * 61'(hb_r1_reg[h]);
            pa2 = 61'(hb_g2_reg[h]) * 61'(hb_r2_reg[h]);
            pb1 = 61'(ha_y1_reg[h]) * 61'(dai_pkg::HORNER_M[K]);
            pb2 = 61'(ha_y2_reg[h]) * 61'(dai_pkg::HORNER_M[K]);
            sh1 = pb1 >> dai_pkg::HORNER_S[K];
            sh2 = pb2 >> dai_pkg::HORNER_S[K];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ha_valid_reg[h]   <= 1'b0;
                hb_valid_reg[h+1] <= 1'b0;
            end
            else if (en)
            begin
                ha_valid_reg[h]   <= hb_valid_reg[h];
                hb_valid_reg[h+1] <= ha_valid_reg[h];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ha_c_reg[h]    <= hb_c_reg[h];
                ha_g1_reg[h]   <= hb_g1_reg[h];
                ha_g2_reg[h]   <= hb_g2_reg[h];
                ha_y1_reg[h]   <= pa1[59:30];
                ha_y2_reg[h]   <= pa2[59:30];
                hb_c_reg[h+1]  <= ha_c_reg[h];
                hb_g1_reg[h+1] <= ha_g1_reg[h];
                hb_g2_reg[h+1] <= ha_g2_reg[h];
                hb_r1_reg[h+1] <= dai_pkg::ONE30 - sh1[30:0];
                hb_r2_reg[h+1] <= dai_pkg::ONE30 - sh2[30:0];
            end
        end
    end

    // Four squarings undo the division of the argument by sixteen.
    logic        sr_valid_reg [0:SQUARES];
    carry_t      sr_c_reg     [0:SQUARES];
    logic [30:0] sr_r1_reg    [0:SQUARES];
    logic [30:0] sr_r2_reg    [0:SQUARES];

    always_comb
    begin
        sr_valid_reg[0] = hb_valid_reg[HORNER];
        sr_c_reg[0]     = hb_c_reg[HORNER];
        sr_r1_reg[0]    = hb_r1_reg[HORNER];
        sr_r2_reg[0]    = hb_r2_reg[HORNER];
    end

    for (genvar s = 0; s < SQUARES; s++)
    begin : g_square
        logic [61:0] q1;
        logic [61:0] q2;

        always_comb
        begin
            q1 = 62'(sr_r1_reg[s]) * 62'(sr_r1_reg[s]) + 62'(1) * 62'(dai_pkg::ONE30 >> 1);
            q2 = 62'(sr_r2_reg[s]) * 62'(sr_r2_reg[s]) + 62'(1) * 62'(dai_pkg::ONE30 >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                sr_valid_reg[s+1] <= sr_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_c_reg[s+1]  <= sr_c_reg[s];
                sr_r1_reg[s+1] <= q1[60:30];
                sr_r2_reg[s+1] <= q2[60:30];
            end
        end
    end

    // Rounding to Q.20 and the albedo-weighted first factor.
    logic [31:0] e1_sum;
    logic [31:0] e2_sum;
    logic [20:0] e1_c;
    logic [21:0] one_e1;
    logic [40:0] p_prod;

    always_comb
    begin
        e1_sum = 32'(sr_r1_reg[SQUARES]) + 32'd512;
        e2_sum = 32'(sr_r2_reg[SQUARES]) + 32'd512;
        e1_c   = e1_sum[30:10];
        one_e1 = 22'(dai_pkg::ONE20) + 22'(e1_c);
        p_prod = 41'(sr_c_reg[SQUARES].mid[24:5]) * 41'(one_e1);
    end

    logic        pp_valid_reg;
    carry_t      pp_c_reg;
    logic [19:0] pp_p_reg;
    logic [20:0] pp_e2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pp_valid_reg <= sr_valid_reg[SQUARES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_c_reg  <= sr_c_reg[SQUARES];
            pp_p_reg  <= p_prod[40:21];
            pp_e2_reg <= e2_sum[30:10];
        end
    end

    // Reflectance, compare against the goal and interval update.
    logic [40:0]         r_prod;
    logic                below;
    dai_pkg::bis_t       next_item;

    always_comb
    begin
        r_prod    = 41'(pp_p_reg) * 41'(pp_e2_reg);
        below     = r_prod[40:20] < pp_c_reg.item.goal;
        next_item = pp_c_reg.item;
        if (below)
        begin
            next_item.low = {1'b0, pp_c_reg.mid};
        end
        else
        begin
            next_item.high = {1'b0, pp_c_reg.mid};
        end
    end

    logic          out_valid_reg;
    dai_pkg::bis_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg <= next_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> hdl/dipole_albedo_inversion_unit.sv
// Top level of the dipole albedo inversion unit: bisection pipeline and ports.
`timescale 1ns / 1ps

//  Channel   Direction  Signals                          Content
//  s_        in         s_tvalid s_tready s_tdata[23:0]  target reflectance, Q1.16
//  m_        out        m_tvalid m_tready m_tdata[23:0]  albedo, Q0.17
//  cfg_      in         cfg_valid cfg_ready cfg_data     boundary term, Q4.16
//
// One beat is accepted every cycle while the result side does not stall; each
// reflectance evaluation runs through 40 stages (square root, division by
// three, twelve Horner steps of two multiplies, four squarings, two products).
// Reset clears all valid bits and loads a boundary term of 1.0.
// While a result beat waits with m_tready low, the whole pipeline holds.
// The configuration channel is always ready.

module dipole_albedo_inversion_unit #(
    parameter int BISECT_STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dai_pkg::TDATA_W-1:0]  s_tdata,   // [16:0] target_reflectance, rest zero
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dai_pkg::TDATA_W-1:0]  m_tdata,   // [16:0] albedo, rest zero
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dai_pkg::BT_W-1:0]     cfg_data
);

    logic                        en;
    logic [dai_pkg::BT_W-1:0]    boundary_term_reg;
    logic [dai_pkg::TGT_W-1:0]   target_c;
    dai_pkg::bis_t               first_item;
    logic                        chain_valid [0:BISECT_STEPS];
    dai_pkg::bis_t               chain_item  [0:BISECT_STEPS];
    logic                        m_valid_reg;
    logic [dai_pkg::ALB_W-1:0]   albedo_reg;
    logic [dai_pkg::LH_W:0]      final_sum;

    // The pipeline moves whenever the output register is free or being taken.
    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Boundary term register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_term_reg <= dai_pkg::BT_RESET;
        end
        else if (cfg_valid)
        begin
            boundary_term_reg <= cfg_data;
        end
    end

    // Clamp the target and open the interval [0, 1].
    always_comb
    begin
        target_c = s_tdata[dai_pkg::TGT_W-1:0];
        if (target_c > dai_pkg::TGT_MAX)
        begin
            target_c = dai_pkg::TGT_MAX;
        end
        first_item.low  = '0;
        first_item.high = dai_pkg::ONE25;
        first_item.goal = {target_c, 4'b0};
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_item[0]  = first_item;

    for (genvar i = 0; i < BISECT_STEPS; i++)
    begin : g_step
        dai_step u_step (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .boundary_term (boundary_term_reg),
            .in_valid      (chain_valid[i]),
            .in_item       (chain_item[i]),
            .out_valid     (chain_valid[i+1]),
            .out_item      (chain_item[i+1])
        );
    end

    // Midpoint of the final interval, truncated to Q0.17.
    assign final_sum = {1'b0, chain_item[BISECT_STEPS].low}
                     + {1'b0, chain_item[BISECT_STEPS].high};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= chain_valid[BISECT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            albedo_reg <= final_sum[dai_pkg::MID_W:9];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dai_pkg::TDATA_W - dai_pkg::ALB_W){1'b0}}, albedo_reg};

endmodule

>>> hdl/dai_checker.sv
// Port checker for the dipole albedo inversion unit, bound to the top level.
`timescale 1ns / 1ps
`include "dipole_albedo_inversion_unit_macros.svh"

module dai_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [dai_pkg::TDATA_W-1:0]  s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dai_pkg::TDATA_W-1:0]  m_tdata,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [dai_pkg::BT_W-1:0]     cfg_data
);

    // A stalled result beat stays put.
    `DAI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Input is taken exactly when the output side lets the pipeline move.
    `DAI_ASSERT_NOW(a_ready_follows, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")

    // Padding bits above the albedo stay clear.
    `DAI_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[23:17] == 7'd0, "result padding not zero")

    // Configuration beats are never refused.
    `DAI_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration beat refused")

endmodule

bind dipole_albedo_inversion_unit dai_checker u_dai_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the dipole albedo inversion unit: predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb;

    localparam int STEPS   = 16;
    localparam int LATENCY = 40 * STEPS + 1;
    localparam logic [dai_pkg::ALB_W-1:0] ALB_TOP = 17'h1FFFF;
    localparam logic [dai_pkg::ALB_W-1:0] ALB_FLOOR = 17'd1;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [dai_pkg::TDATA_W-1:0]  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [dai_pkg::TDATA_W-1:0]  m_tdata;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [dai_pkg::BT_W-1:0]     cfg_data;

    // Boundary term the block holds, as the bench believes it.
    logic [dai_pkg::BT_W-1:0]     boundary_q416;
    // Albedo values still owed by the block, oldest first.
    logic [dai_pkg::ALB_W-1:0]    albedo_due[$];
    int                           errors;
    int                           cycle_no;

    dipole_albedo_inversion_unit #(
        .BISECT_STEPS(STEPS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [16:0] target_reflectance, rest zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [16:0] albedo, rest zero
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Exact integer square root.
    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // exp(-x) with x in Q4.20, result in Q.20.
    function automatic longint unsigned decay_q20(longint unsigned x);
        longint unsigned g;
        longint unsigned r;
        if (x > 64'hFFFFFF)
            x = 64'hFFFFFF;
        g = x << 6;
        r = 64'd1 << 30;
        for (int k = 12; k >= 1; k--)
            r = (64'd1 << 30) - ((g * r) >> 30) / k;
        for (int k = 0; k < 4; k++)
            r = (r * r + (64'd1 << 29)) >> 30;
        return (r + (64'd1 << 9)) >> 10;
    endfunction

    // Dipole diffuse reflectance at albedo a (Q.20), in Q.20.
    function automatic longint unsigned reflectance_q20(longint unsigned a,
                                                        longint unsigned bt);
        longint unsigned t;
        longint unsigned e;
        longint unsigned x1;
        longint unsigned p;
        if (a > (64'd1 << 20))
            a = 64'd1 << 20;
        t  = 3 * ((64'd1 << 20) - a);
        e  = sqrt_floor(t << 20);
        x1 = (4 * bt * e) / (64'd3 << 16);
        if (x1 > 64'hFFFFFF)
            x1 = 64'hFFFFFF;
        p = (a * ((64'd1 << 20) + decay_q20(x1))) >> 21;
        return (p * decay_q20(e)) >> 20;
    endfunction

    // Bisection for the albedo that meets the target reflectance.
    function automatic logic [dai_pkg::ALB_W-1:0] invert_albedo(
        logic [dai_pkg::TGT_W-1:0] target, logic [dai_pkg::BT_W-1:0] bt);
        longint unsigned goal;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 25;
        goal = (target > dai_pkg::TGT_MAX) ? (64'(dai_pkg::TGT_MAX) << 4)
                                           : (64'(target) << 4);
        for (int i = 0; i < STEPS; i++)
        begin
            mid = (lo + hi) >> 1;
            if (reflectance_q20(mid >> 5, 64'(bt)) < goal)
                lo = mid;
            else
                hi = mid;
        end
        mid = (lo + hi) >> 1;
        return dai_pkg::ALB_W'(mid >> 8);
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (albedo_due.size() == 0)
            begin
                $error("albedo: expected none, actual %0d", m_tdata[dai_pkg::ALB_W-1:0]);
                errors = errors + 1;
            end
            else
            begin
                if (m_tdata[dai_pkg::ALB_W-1:0] !== albedo_due[0])
                begin
                    $error("albedo: expected %0d, actual %0d",
                           albedo_due[0], m_tdata[dai_pkg::ALB_W-1:0]);
                    errors = errors + 1;
                end
                if (m_tdata[dai_pkg::TDATA_W-1:dai_pkg::ALB_W] !== '0)
                begin
                    $error("padding: expected 0, actual %0h",
                           m_tdata[dai_pkg::TDATA_W-1:dai_pkg::ALB_W]);
                    errors = errors + 1;
                end
                void'(albedo_due.pop_front());
            end
        end
    end

    // Receiver stalls, in one of four modes that is drawn anew at random.
    initial
    begin
        int mode;
        m_tready = 1'b0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (cycle_no % 300 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = (cycle_no % 3) != 0;
                2: m_tready = $urandom_range(0, 1);
                default: m_tready = (cycle_no % 64) >= 20;
            endcase
        end
    end

    // Offer one target beat and record its expected albedo on acceptance.
    task automatic send_target(logic [dai_pkg::TGT_W-1:0] target, bit typed,
                               logic [dai_pkg::ALB_W-1:0] albedo_typed);
        s_tdata  = dai_pkg::TDATA_W'(target);
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        albedo_due.push_back(typed ? albedo_typed : invert_albedo(target, boundary_q416));
        @(negedge clk);
    endtask

    // Random gap after a beat, ending the current burst now and then.
    task automatic burst_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 12))
            @(negedge clk);
        burst_left = $urandom_range(0, 30);
    endtask

    // Wait for the pipeline to drain before a register write or the end.
    task automatic drain_pipe();
        s_tvalid = 1'b0;
        while (albedo_due.size() != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic write_boundary(logic [dai_pkg::BT_W-1:0] value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        boundary_q416 = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [dai_pkg::TGT_W-1:0] random_target();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return dai_pkg::TGT_W'($urandom_range(65537, 131071));
        if (pick == 1)
            return dai_pkg::TGT_W'($urandom_range(0, 64));
        if (pick == 2)
            return dai_pkg::TGT_W'($urandom_range(65000, 65536));
        return dai_pkg::TGT_W'($urandom_range(0, 65536));
    endfunction

    // Directed targets: value, whether the albedo is typed, typed albedo.
    typedef struct {
        logic [dai_pkg::TGT_W-1:0] target;
        bit                        typed;
        logic [dai_pkg::ALB_W-1:0] albedo;
    } target_row_t;

    target_row_t directed[] = '{
        '{17'd0,      1'b1, ALB_FLOOR},
        '{17'd65536,  1'b1, ALB_TOP},
        '{17'd131071, 1'b1, ALB_TOP},
        '{17'd65537,  1'b1, ALB_TOP},
        '{17'd1,      1'b0, '0},
        '{17'd2,      1'b0, '0},
        '{17'd16,     1'b0, '0},
        '{17'd256,    1'b0, '0},
        '{17'd4096,   1'b0, '0},
        '{17'd16384,  1'b0, '0},
        '{17'd32768,  1'b0, '0},
        '{17'd43690,  1'b0, '0},
        '{17'd52428,  1'b0, '0},
        '{17'd60000,  1'b0, '0},
        '{17'd65535,  1'b0, '0},
        '{17'd65280,  1'b0, '0},
        '{17'd21845,  1'b0, '0},
        '{17'd0,      1'b1, ALB_FLOOR}
    };

    // Main sequence: reset, directed rows, then phases of random targets.
    initial
    begin
        logic [dai_pkg::BT_W-1:0] settings[8];
        int burst_left;
        errors        = 0;
        cycle_no      = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        boundary_q416 = dai_pkg::BT_RESET;
        burst_left    = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_target(directed[i].target, directed[i].typed, directed[i].albedo);
            burst_gap(burst_left);
        end
        drain_pipe();

        settings = '{20'd65536, 20'd0, 20'hFFFFF, 20'd65535, 20'd98304,
                     dai_pkg::BT_W'($urandom_range(65536, 1048575)),
                     dai_pkg::BT_W'($urandom_range(65536, 1048575)),
                     dai_pkg::BT_W'($urandom_range(0, 1048575))};
        foreach (settings[p])
        begin
            write_boundary(settings[p]);
            if (p < 3)
            begin
                send_target(17'd0, 1'b1, ALB_FLOOR);
                send_target(dai_pkg::TGT_MAX, 1'b1, ALB_TOP);
            end
            repeat (172)
            begin
                send_target(random_target(), 1'b0, '0);
                burst_gap(burst_left);
            end
            drain_pipe();
        end

        repeat (LATENCY + 50)
            @(negedge clk);
        if (albedo_due.size() != 0)
        begin
            $error("albedo: expected %0d more results, actual none", albedo_due.size());
            errors++;
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
